// File: hw/rtl/wsht_pkg.sv
`default_nettype none

package wsht_pkg;

  // Field widths fixed by the command format
  localparam int SLOT_BITS   = 4;
  localparam int COUNT_BITS  = 5;
  localparam int NUMBER_BITS = 5;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CLICK = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_PLACE
  } wsht_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/wsht_ram.sv
`default_nettype none

module wsht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/window_stack_hit_test_unit.sv
`default_nettype none

// Window stack hit tester. A load (cmd low) writes one slot's rectangle and
// restores the initial stacking, higher slot on top; it leaves busy low and
// gives no result. A click (cmd high) tests the point against the windows
// from the top down and raises the first window that contains it to the top.
// Its result is shown for one cycle on done, hit and window_number once the
// walk reaches the hit window, or passes the bottom window on a miss, and in
// the cycle after the click is taken when no window is in use. The receiver
// cannot stall: results must be taken when done is high. After a hit on any
// window but the top one the block stays busy after the result is shown while
// the stacking order is rewritten. The walk issues one window a cycle through
// the order memory and the rectangle memory, each with a registered read; the
// reorder moves one entry a cycle over the single write port of the order
// memory. Writes of window_count are taken while busy is low and also restore
// the initial stacking.
module window_stack_hit_test_unit #(
  parameter int MAX_WINDOWS = 16,
  parameter int COORD_BITS  = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd,
  input  wire logic [wsht_pkg::SLOT_BITS-1:0]    slot,
  input  wire logic [COORD_BITS-1:0]             left_x,
  input  wire logic [COORD_BITS-1:0]             bottom_y,
  input  wire logic [COORD_BITS-1:0]             right_x,
  input  wire logic [COORD_BITS-1:0]             top_y,
  input  wire logic [COORD_BITS-1:0]             point_x,
  input  wire logic [COORD_BITS-1:0]             point_y,
  output logic                                   done,
  output logic                                   hit,
  output logic      [wsht_pkg::NUMBER_BITS-1:0]  window_number,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wsht_pkg::COUNT_BITS-1:0]   cfg_data
);

  import wsht_pkg::*;

  localparam int SLOT_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
  localparam int RECT_W = 4 * COORD_BITS;

  wsht_state_t state, state_next;

  logic [COUNT_BITS-1:0]  window_count;
  logic [CNT_W-1:0]       n_sat;
  logic [CNT_W-1:0]       n_reg;
  logic [SLOT_W-1:0]      top_pos;
  logic [COORD_BITS-1:0]  px, py;

  // Order list: entry k holds the slot at rank k+1; an invalid entry holds k
  logic [MAX_WINDOWS-1:0] ord_vld;
  logic                   ord_we;
  logic [SLOT_W-1:0]      ord_waddr, ord_wdata, ord_raddr, ord_rdata;

  logic                   rect_we;
  logic [SLOT_W-1:0]      rect_waddr;
  logic [RECT_W-1:0]      rect_wdata, rect_rdata;

  // Walk pipeline
  logic                   issue_on;
  logic [SLOT_W-1:0]      ic;
  logic                   s1_v, s1_ovld;
  logic [SLOT_W-1:0]      s1_pos, s1_slot;
  logic                   s2_v;
  logic [SLOT_W-1:0]      s2_pos, s2_slot;
  logic                   hit_now;

  // Reorder
  logic [SLOT_W-1:0]      hit_pos, hit_slot;
  logic                   rd_on;
  logic [SLOT_W-1:0]      rc;
  logic                   w_v, w_ovld;
  logic [SLOT_W-1:0]      w_src;

  logic                   accept, cfg_write, slot_ok;
  logic [COORD_BITS-1:0]  r_left, r_bottom, r_right, r_top;

  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign slot_ok   = int'(slot) < MAX_WINDOWS;
  assign n_sat     = (int'(window_count) > MAX_WINDOWS) ? CNT_W'(MAX_WINDOWS)
                                                        : CNT_W'(window_count);
  assign top_pos   = SLOT_W'(n_reg - CNT_W'(1));

  // Resolve the slot from the order memory, falling back to the initial order
  assign s1_slot = s1_ovld ? ord_rdata : s1_pos;

  // Containment test, all edges inclusive
  assign {r_left, r_bottom, r_right, r_top} = rect_rdata;
  assign hit_now = (r_left <= px) && (px <= r_right) &&
                   (r_bottom <= py) && (py <= r_top);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_CLICK && n_sat != '0) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (s2_v) begin
          if (hit_now) begin
            state_next = (s2_pos == top_pos) ? ST_IDLE : ST_SHIFT;
          end else if (s2_pos == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SHIFT: begin
        if (!rd_on && w_v) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory controls and handshake outputs
  always_comb begin
    busy       = state != ST_IDLE;
    cfg_ready  = state == ST_IDLE;
    rect_we    = accept && cmd == CMD_LOAD && slot_ok;
    rect_waddr = SLOT_W'(slot);
    rect_wdata = {left_x, bottom_y, right_x, top_y};
    ord_raddr  = ic;
    ord_we     = 1'b0;
    ord_waddr  = w_src - SLOT_W'(1);
    ord_wdata  = w_ovld ? ord_rdata : w_src;
    unique case (state)
      ST_IDLE, ST_WALK: begin
      end
      ST_SHIFT: begin
        ord_raddr = rc;
        ord_we    = w_v;
      end
      ST_PLACE: begin
        ord_we    = 1'b1;
        ord_waddr = top_pos;
        ord_wdata = hit_slot;
      end
      default: begin
      end
    endcase
  end

  wsht_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_WINDOWS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  wsht_ram #(.WIDTH(RECT_W), .DEPTH(MAX_WINDOWS)) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (rect_waddr),
    .wdata (rect_wdata),
    .raddr (s1_slot),
    .rdata (rect_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_count <= COUNT_RESET;
      ord_vld      <= '0;
      done         <= 1'b0;
      issue_on     <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      rd_on        <= 1'b0;
      w_v          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      // Mark written order entries
      if (ord_we) begin
        ord_vld[ord_waddr] <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          s1_v <= 1'b0;
          s2_v <= 1'b0;
          w_v  <= 1'b0;
          if (cfg_write) begin
            window_count <= cfg_data;
            ord_vld      <= '0;
          end
          if (accept && cmd == CMD_LOAD && slot_ok) begin
            ord_vld <= '0;
          end
          if (accept && cmd == CMD_CLICK) begin
            if (n_sat == '0) begin
              done <= 1'b1;
            end else begin
              issue_on <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          // Advance the walk one window a cycle
          s1_v <= issue_on;
          s2_v <= s1_v;
          if (issue_on && ic == '0) begin
            issue_on <= 1'b0;
          end
          if (s2_v && (hit_now || s2_pos == '0)) begin
            done     <= 1'b1;
            issue_on <= 1'b0;
            rd_on    <= 1'b1;
          end
        end
        ST_SHIFT: begin
          // Move entries above the hit down by one
          w_v <= rd_on;
          if (rd_on && rc == top_pos) begin
            rd_on <= 1'b0;
          end
        end
        ST_PLACE: begin
          w_v <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n_reg         <= n_sat;
        px            <= point_x;
        py            <= point_y;
        ic            <= SLOT_W'(n_sat - CNT_W'(1));
        hit           <= 1'b0;
        window_number <= '0;
      end
      ST_WALK: begin
        s1_pos  <= ic;
        s1_ovld <= ord_vld[ic];
        if (issue_on && ic != '0) begin
          ic <= ic - SLOT_W'(1);
        end
        s2_pos  <= s1_pos;
        s2_slot <= s1_slot;
        if (s2_v && (hit_now || s2_pos == '0)) begin
          hit           <= hit_now;
          window_number <= hit_now ? NUMBER_BITS'(int'(s2_slot) + 1) : '0;
          hit_pos       <= s2_pos;
          hit_slot      <= s2_slot;
          rc            <= s2_pos + SLOT_W'(1);
        end
      end
      ST_SHIFT: begin
        w_src  <= rc;
        w_ovld <= ord_vld[rc];
        if (rd_on && rc != top_pos) begin
          rc <= rc + SLOT_W'(1);
        end
      end
      ST_PLACE: begin
      end
      default: begin
      end
    endcase
  end

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (!done || $past(cmd) == CMD_CLICK))
    else $error("result after a load");

  // The bottom window ends the walk either way
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && s2_v && s2_pos == '0) |=> state != ST_WALK)
    else $error("walk ran past the bottom window");

  // Reorder reads stay above the hit and within the windows in use
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT && rd_on) |-> (rc <= top_pos && rc > hit_pos))
    else $error("reorder cursor out of range");

  // The hit window is placed only after the last moved entry is written
  a_place_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_PLACE |-> ($past(state) == ST_SHIFT && $past(w_v)))
    else $error("top entry placed before reorder finished");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import wsht_pkg::*;

  localparam int MAX_WIN       = 16;
  localparam int COORD         = 12;
  localparam int SETTLE_CYCLES = MAX_WIN + 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int ITEM_TARGET   = 1550;

  typedef logic [COORD-1:0] coord_t;

  typedef struct {
    logic                 cmd;
    logic [SLOT_BITS-1:0] slot;
    coord_t               left_x, bottom_y, right_x, top_y;
    coord_t               point_x, point_y;
  } window_cmd_t;

  typedef struct {
    coord_t left_x, bottom_y, right_x, top_y;
  } rect_t;

  typedef struct {
    logic                   hit;
    logic [NUMBER_BITS-1:0] number;
  } click_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cmd = CMD_LOAD;
  logic [SLOT_BITS-1:0]   slot = '0;
  coord_t                 left_x = '0;
  coord_t                 bottom_y = '0;
  coord_t                 right_x = '0;
  coord_t                 top_y = '0;
  coord_t                 point_x = '0;
  coord_t                 point_y = '0;
  logic                   done;
  logic                   hit;
  logic [NUMBER_BITS-1:0] window_number;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_BITS-1:0]  cfg_data = '0;

  window_stack_hit_test_unit #(
    .MAX_WINDOWS(MAX_WIN),
    .COORD_BITS (COORD)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot         (slot),
    .left_x       (left_x),
    .bottom_y     (bottom_y),
    .right_x      (right_x),
    .top_y        (top_y),
    .point_x      (point_x),
    .point_y      (point_y),
    .done         (done),
    .hit          (hit),
    .window_number(window_number),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Mirror of the window stack
  rect_t                  win_rect [MAX_WIN];
  logic [NUMBER_BITS-1:0] z_rank [MAX_WIN];
  logic [COUNT_BITS-1:0]  win_count;
  click_result_t          click_results_due [$];

  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int windows_in_use();
    return (win_count > MAX_WIN) ? MAX_WIN : int'(win_count);
  endfunction

  // Put every slot back at its initial height, higher slot on top
  function automatic void restack();
    for (int s = 0; s < MAX_WIN; s++) z_rank[s] = NUMBER_BITS'(s + 1);
  endfunction

  function automatic bit covers(rect_t r, coord_t x, coord_t y);
    return r.left_x <= x && x <= r.right_x && r.bottom_y <= y && y <= r.top_y;
  endfunction

  function automatic void set_count(logic [COUNT_BITS-1:0] v);
    win_count = v;
    restack();
  endfunction

  // Apply one accepted beat to the stack and queue the click outcome
  function automatic void advance_stack(window_cmd_t c);
    int                     n;
    int                     hit_slot;
    bit                     found;
    logic [NUMBER_BITS-1:0] old_rank;
    click_result_t          res;
    n = windows_in_use();
    hit_slot = 0;
    found = 1'b0;
    if (c.cmd == CMD_LOAD) begin
      win_rect[c.slot] = '{c.left_x, c.bottom_y, c.right_x, c.top_y};
      restack();
    end else begin
      // Walk from the top rank down; the first containing window wins
      for (int lvl = n; lvl >= 1 && !found; lvl--) begin
        for (int s = 0; s < n; s++) begin
          if (!found && z_rank[s] == NUMBER_BITS'(lvl)) begin
            if (covers(win_rect[s], c.point_x, c.point_y)) begin
              found = 1'b1;
              hit_slot = s;
            end
          end
        end
      end
      if (found) begin
        old_rank = z_rank[hit_slot];
        if (old_rank != NUMBER_BITS'(n)) begin
          for (int s = 0; s < n; s++) begin
            if (s != hit_slot && z_rank[s] > old_rank) z_rank[s] = z_rank[s] - 1'b1;
          end
          z_rank[hit_slot] = NUMBER_BITS'(n);
        end
        res.hit = 1'b1;
        res.number = NUMBER_BITS'(hit_slot + 1);
      end else begin
        res.hit = 1'b0;
        res.number = '0;
      end
      click_results_due.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Compare each strobed result with the oldest pending click
  always @(posedge clk) begin : check_results
    click_result_t want;
    if (!rst && done) begin
      if (click_results_due.size() == 0) begin
        report_mismatch("unexpected result, window_number", window_number, 0);
      end else begin
        want = click_results_due.pop_front();
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (window_number !== want.number)
          report_mismatch("window_number", window_number, want.number);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic window_cmd_t random_fields();
    window_cmd_t c;
    c.cmd = CMD_CLICK;
    c.slot = SLOT_BITS'($urandom);
    c.left_x = coord_t'($urandom);
    c.bottom_y = coord_t'($urandom);
    c.right_x = coord_t'($urandom);
    c.top_y = coord_t'($urandom);
    c.point_x = coord_t'($urandom);
    c.point_y = coord_t'($urandom);
    return c;
  endfunction

  // Drive one command beat and hold it until the block takes it
  task automatic send_item(window_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c.cmd;
    slot <= c.slot;
    left_x <= c.left_x;
    bottom_y <= c.bottom_y;
    right_x <= c.right_x;
    top_y <= c.top_y;
    point_x <= c.point_x;
    point_y <= c.point_y;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_stack(c);
    items_sent++;
  endtask

  // Write the window count once all clicks are answered and the block is quiet
  task automatic write_count(logic [COUNT_BITS-1:0] v);
    start <= 1'b0;
    while (click_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_count(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_window(int s, int l, int b, int r, int t);
    window_cmd_t c;
    c = random_fields();
    c.cmd = CMD_LOAD;
    c.slot = SLOT_BITS'(s);
    c.left_x = coord_t'(l);
    c.bottom_y = coord_t'(b);
    c.right_x = coord_t'(r);
    c.top_y = coord_t'(t);
    send_item(c, pick_gap());
  endtask

  task automatic click_at(int x, int y);
    window_cmd_t c;
    c = random_fields();
    c.cmd = CMD_CLICK;
    c.point_x = coord_t'(x);
    c.point_y = coord_t'(y);
    send_item(c, pick_gap());
  endtask

  // Mostly overlapping mid-sized windows, plus wild, full-screen and point ones
  function automatic window_cmd_t make_load(int s);
    window_cmd_t c;
    int unsigned roll;
    c = random_fields();
    c.cmd = CMD_LOAD;
    c.slot = SLOT_BITS'(s);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      c.left_x = coord_t'($urandom_range(0, 1535));
      c.right_x = c.left_x + coord_t'($urandom_range(0, 1200));
      c.bottom_y = coord_t'($urandom_range(0, 1535));
      c.top_y = c.bottom_y + coord_t'($urandom_range(0, 1200));
    end else if (roll < 80) begin
      // keep the fully random edges, inverted ones included
    end else if (roll < 90) begin
      c.left_x = '0;
      c.bottom_y = '0;
      c.right_x = '1;
      c.top_y = '1;
    end else begin
      c.right_x = c.left_x;
      c.top_y = c.bottom_y;
    end
    return c;
  endfunction

  function automatic coord_t near_span(coord_t lo, coord_t hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return coord_t'(lo - 1);
      3: return coord_t'(hi + 1);
      default: return coord_t'($urandom_range(hi, lo));
    endcase
  endfunction

  // Aim most clicks at or around a window in use
  function automatic window_cmd_t make_click(int n);
    window_cmd_t c;
    rect_t       r;
    c = random_fields();
    c.cmd = CMD_CLICK;
    if (n > 0 && $urandom_range(0, 99) < 80) begin
      r = win_rect[$urandom_range(0, n - 1)];
      if (r.left_x <= r.right_x && r.bottom_y <= r.top_y) begin
        c.point_x = near_span(r.left_x, r.right_x);
        c.point_y = near_span(r.bottom_y, r.top_y);
      end
    end
    return c;
  endfunction

  // One window at the reset count of one, inclusive edges
  task automatic test_reset_count();
    load_window(0, 10, 20, 30, 40);
    click_at(10, 20);
    click_at(30, 40);
    click_at(31, 40);
    click_at(10, 19);
  endtask

  // Raise a lower window, hit the top one, and restack on a load
  task automatic test_move_to_front();
    write_count(3);
    load_window(0, 0, 0, 4095, 4095);
    load_window(1, 100, 100, 200, 200);
    load_window(2, 150, 150, 250, 250);
    click_at(160, 160);
    click_at(120, 120);
    click_at(160, 160);
    click_at(4095, 4095);
    click_at(0, 0);
    load_window(5, 300, 300, 400, 400);
    click_at(160, 160);
    click_at(120, 120);
  endtask

  // No window in use, then an inverted window over a single-point one
  task automatic test_empty_and_inverted();
    write_count(0);
    click_at(5, 5);
    write_count(2);
    load_window(0, 4095, 0, 4095, 0);
    load_window(1, 4095, 4095, 0, 0);
    click_at(4095, 0);
    click_at(4095, 0);
  endtask

  // Phases at several counts: refill the slots in use, then mostly clicks
  task automatic test_random_phases();
    int                    phase;
    int                    n;
    int                    len;
    logic [COUNT_BITS-1:0] val;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: val = COUNT_BITS'(MAX_WIN);
        1: val = '1;
        2: val = '0;
        3: val = COUNT_BITS'(MAX_WIN + 1);
        4: val = COUNT_BITS'(1);
        5: val = COUNT_BITS'(2);
        default: val = ($urandom_range(0, 1) != 0) ? COUNT_BITS'($urandom_range(2, MAX_WIN))
                                                   : COUNT_BITS'($urandom_range(0, 31));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      write_count(val);
      n = windows_in_use();
      for (int k = 0; k < n; k++) send_item(make_load(k), pick_gap());
      len = $urandom_range(40, 120);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 12)
          send_item(make_load($urandom_range(0, MAX_WIN - 1)), pick_gap());
        else
          send_item(make_click(n), pick_gap());
      end
      phase++;
    end
  endtask

  initial begin
    for (int s = 0; s < MAX_WIN; s++) begin
      win_rect[s] = '{default: '0};
    end
    set_count(COUNT_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_count();
    test_move_to_front();
    test_empty_and_inverted();
    test_random_phases();

    // Drain outstanding clicks and let the reorder settle
    start <= 1'b0;
    while (click_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && click_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wsht_pkg.sv
hw/rtl/wsht_ram.sv
hw/rtl/window_stack_hit_test_unit.sv
tb/tb.sv
